/* design/gse_pkg.sv */
package gse_pkg;

  localparam int unsigned ADC_W      = 12;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned EXP_STEPS  = 16;
  localparam int unsigned MANT_W     = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOAD_RES  = 4'd0,
    REG_SCALE     = 4'd1,
    REG_EXPONENT  = 4'd2,
    REG_CLEAN_AIR = 4'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_ABORTED    = 2'd1,
    ST_CALIBRATED = 2'd2,
    ST_SKIPPED    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LATCH,
    OP_DIV_SENSOR,
    OP_DIV_STEP,
    OP_CAL_DIV,
    OP_CAL_SET,
    OP_CAL_SKIP,
    OP_ABORT,
    OP_ACCUM,
    OP_DIV_AVG,
    OP_DIV_RATIO,
    OP_NORM_LOAD,
    OP_NORM_STEP,
    OP_LOG_INIT,
    OP_SQ_MUL,
    OP_SQ_UPD,
    OP_EXP_E,
    OP_EXP_INIT,
    OP_EXP_MUL,
    OP_EXP_UPD,
    OP_SCALE_MUL,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic op_cal;
    logic rdy;
    logic adc_zero;
    logic div_last;
    logic run_full;
    logic norm_done;
    logic it_last;
    logic stop_early;
  } dp_stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem_v;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem_v = n;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem_v >= res + bit_v) begin
        rem_v = rem_v - (res + bit_v);
        res   = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // c_k = 2^(2^-k) in q1.30, k = 1 in the lowest slot
  function automatic logic [EXP_STEPS*MANT_W-1:0] exp_coefs();
    logic [EXP_STEPS*MANT_W-1:0] tab;
    logic [63:0] c;
    c = isqrt64(64'd1 << 61);
    for (int k = 0; k < EXP_STEPS; k++) begin
      tab[k*MANT_W +: MANT_W] = c[MANT_W-1:0];
      c = isqrt64(c << 30);
    end
    return tab;
  endfunction

endpackage

/* design/gse_datapath.sv */
module gse_datapath #(
  parameter int unsigned SAMPLES_PER_READING = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gse_pkg::dp_cmd_t               cmd,
  output gse_pkg::dp_stat_t              stat,
  input  logic                           in_op,
  input  logic [gse_pkg::ADC_W-1:0]      in_adc,
  input  logic                           in_rdy,
  input  logic                           cfg_wr,
  input  logic [gse_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [15:0]                    out_ppm,
  output logic [1:0]                     out_status,
  output logic [31:0]                    out_ref
);
  import gse_pkg::*;

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_READING + 1);
  localparam logic [CNT_W-1:0] RUN_LEN = CNT_W'(SAMPLES_PER_READING);
  localparam logic [EXP_STEPS*MANT_W-1:0] EXP_COEFS = exp_coefs();

  logic [15:0]              load_r;
  logic [23:0]              scale_r;
  logic signed [15:0]       expo_r;
  logic [15:0]              car_r;
  logic [31:0]              ref_r;
  logic [39:0]              sum_r;
  logic [CNT_W-1:0]         samples;
  logic                     op_r;
  logic [ADC_W-1:0]         adc_r;
  logic                     rdy_r;
  logic [47:0]              num;
  logic [31:0]              den;
  logic [31:0]              rem;
  logic [5:0]               step;
  logic [5:0]               p;
  logic [MANT_W-1:0]        mant;
  logic [15:0]              frac;
  logic signed [26:0]       e_r;
  logic [2*MANT_W-1:0]      prod;
  logic [15:0]              res_ppm;
  status_t                  res_status;

  logic [32:0]              rem_sh;
  logic [33:0]              diff;
  logic                     q_bit;
  logic [31:0]              rem_next;
  logic [28:0]              lr_prod;
  logic [MANT_W-1:0]        mul_a;
  logic [MANT_W-1:0]        mul_b;
  logic [2*MANT_W-1:0]      prod_w;
  logic [MANT_W-1:0]        coef;
  logic [6:0]               pm8;
  logic signed [22:0]       log_val;
  logic signed [38:0]       e_prod;
  logic signed [10:0]       ip;
  logic signed [11:0]       sh;
  logic [54:0]              shifted;
  logic [15:0]              fin_ppm;
  logic [40:0]              acc_sum;
  logic [39:0]              r_val;

  // restoring divider step
  assign rem_sh   = {rem, num[47]};
  assign diff     = {1'b0, rem_sh} - {2'b00, den};
  assign q_bit    = ~diff[33];
  assign rem_next = q_bit ? diff[31:0] : rem_sh[31:0];

  assign lr_prod = 29'(load_r) * 29'(13'd4096 - {1'b0, adc_r});

  always_comb begin
    unique case (cmd.op)
      OP_SQ_MUL: begin
        mul_a = mant;
        mul_b = mant;
      end
      OP_EXP_MUL: begin
        mul_a = mant;
        mul_b = coef;
      end
      default: begin
        mul_a = {{(MANT_W-24){1'b0}}, scale_r};
        mul_b = mant;
      end
    endcase
  end
  assign prod_w = {{MANT_W{1'b0}}, mul_a} * {{MANT_W{1'b0}}, mul_b};
  assign coef   = EXP_COEFS[step[3:0]*MANT_W +: MANT_W];

  assign pm8     = {1'b0, p} - 7'd8;
  assign log_val = signed'({pm8, frac});
  assign e_prod  = 39'(log_val) * 39'(expo_r);

  assign ip      = e_r[26:16];
  assign sh      = 12'sd38 - {ip[10], ip};
  assign shifted = prod[54:0] >> sh[5:0];

  always_comb begin
    priority if (scale_r == 24'd0) begin
      fin_ppm = 16'd0;
    end else if (num == 48'd0) begin
      priority if (expo_r < 0) begin
        fin_ppm = 16'hFFFF;
      end else if (expo_r == 16'sd0) begin
        fin_ppm = scale_r[23:8];
      end else begin
        fin_ppm = 16'd0;
      end
    end else if (sh[11] || sh == 12'sd0) begin
      fin_ppm = 16'hFFFF;
    end else if (sh[11:6] != 6'd0) begin
      fin_ppm = 16'd0;
    end else if (shifted[54:16] != '0) begin
      fin_ppm = 16'hFFFF;
    end else begin
      fin_ppm = shifted[15:0];
    end
  end

  assign r_val   = (adc_r == '0) ? 40'd0 : num[39:0];
  assign acc_sum = {1'b0, sum_r} + {1'b0, r_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      load_r  <= 16'd1000;
      scale_r <= 24'd19777;
      expo_r  <= -16'sd6709;
      car_r   <= 16'd15360;
      ref_r   <= 32'd256000;
      sum_r   <= '0;
      samples <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_LOAD_RES:  load_r  <= cfg_wdata[15:0];
          REG_SCALE:     scale_r <= cfg_wdata;
          REG_EXPONENT:  expo_r  <= signed'(cfg_wdata[15:0]);
          REG_CLEAN_AIR: car_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_CAL_SET: ref_r <= (num[47:32] != '0) ? 32'hFFFF_FFFF : num[31:0];
        OP_ABORT, OP_FINISH: begin
          sum_r   <= '0;
          samples <= '0;
        end
        OP_ACCUM: begin
          sum_r   <= acc_sum[40] ? 40'hFF_FFFF_FFFF : acc_sum[39:0];
          samples <= samples + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        op_r  <= in_op;
        adc_r <= in_adc;
        rdy_r <= in_rdy;
      end
      OP_DIV_SENSOR: begin
        num  <= {11'd0, lr_prod, 8'd0};
        den  <= {20'd0, adc_r};
        rem  <= '0;
        step <= '0;
      end
      OP_DIV_STEP: begin
        num  <= {num[46:0], q_bit};
        rem  <= rem_next;
        step <= step + 1'b1;
      end
      OP_CAL_DIV: begin
        num  <= {num[39:0], 8'd0};
        den  <= {16'd0, (car_r == '0) ? 16'd1 : car_r};
        rem  <= '0;
        step <= '0;
      end
      OP_CAL_SET: begin
        res_ppm    <= '0;
        res_status <= ST_CALIBRATED;
      end
      OP_CAL_SKIP: begin
        res_ppm    <= '0;
        res_status <= ST_SKIPPED;
      end
      OP_ABORT: begin
        res_ppm    <= '0;
        res_status <= ST_ABORTED;
      end
      OP_DIV_AVG: begin
        num  <= {8'd0, sum_r};
        den  <= 32'(SAMPLES_PER_READING);
        rem  <= '0;
        step <= '0;
      end
      OP_DIV_RATIO: begin
        num  <= {num[39:0], 8'd0};
        den  <= (ref_r == '0) ? 32'd1 : ref_r;
        rem  <= '0;
        step <= '0;
      end
      OP_NORM_LOAD: p <= 6'd47;
      OP_NORM_STEP: begin
        if (!num[47]) begin
          num <= {num[46:0], 1'b0};
          p   <= p - 1'b1;
        end
      end
      OP_LOG_INIT: begin
        mant <= num[47:17];
        frac <= '0;
        step <= '0;
      end
      OP_SQ_MUL, OP_EXP_MUL, OP_SCALE_MUL: prod <= prod_w;
      OP_SQ_UPD: begin
        frac <= {frac[14:0], prod[61]};
        mant <= prod[61] ? prod[61:31] : prod[60:30];
        step <= step + 1'b1;
      end
      OP_EXP_E: e_r <= e_prod[38:12];
      OP_EXP_INIT: begin
        mant <= MANT_W'(1) << 30;
        step <= '0;
      end
      OP_EXP_UPD: begin
        if (e_r[4'd15 - step[3:0]]) begin
          mant <= prod[60:30];
        end
        step <= step + 1'b1;
      end
      OP_FINISH: begin
        res_ppm    <= fin_ppm;
        res_status <= ST_DONE;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      out_ppm    <= res_ppm;
      out_status <= res_status;
      out_ref    <= ref_r;
    end
  end

  assign stat.op_cal     = op_r;
  assign stat.rdy        = rdy_r;
  assign stat.adc_zero   = (adc_r == '0);
  assign stat.div_last   = (step == 6'(DIV_STEPS - 1));
  assign stat.run_full   = (samples == RUN_LEN);
  assign stat.norm_done  = num[47];
  assign stat.it_last    = (step == 6'(EXP_STEPS - 1));
  assign stat.stop_early = (scale_r == '0) || (num == '0);

endmodule

/* design/gse_ctrl.sv */
module gse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gse_pkg::dp_stat_t stat,
  output gse_pkg::dp_cmd_t  cmd
);
  import gse_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_LD_R, S_DIV_R, S_LD_CAL, S_DIV_CAL, S_CAL_SET,
    S_CAL_SKIP, S_ABORT, S_ACCUM, S_CHECK, S_LD_AVG, S_DIV_AVG, S_LD_RAT,
    S_DIV_RAT, S_NORM_LD, S_NORM, S_LOG_INIT, S_SQ_MUL, S_SQ_UPD, S_EXP_E,
    S_EXP_INIT, S_EX_MUL, S_EX_UPD, S_SCALE, S_FINISH, S_OUT
  } state_t;

  state_t state;
  logic   load_out;

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    cmd.load_out = load_out;
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? OP_LATCH : OP_IDLE;
      S_LD_R:     cmd.op = OP_DIV_SENSOR;
      S_DIV_R, S_DIV_CAL, S_DIV_AVG, S_DIV_RAT: cmd.op = OP_DIV_STEP;
      S_LD_CAL:   cmd.op = OP_CAL_DIV;
      S_CAL_SET:  cmd.op = OP_CAL_SET;
      S_CAL_SKIP: cmd.op = OP_CAL_SKIP;
      S_ABORT:    cmd.op = OP_ABORT;
      S_ACCUM:    cmd.op = OP_ACCUM;
      S_LD_AVG:   cmd.op = OP_DIV_AVG;
      S_LD_RAT:   cmd.op = OP_DIV_RATIO;
      S_NORM_LD:  cmd.op = OP_NORM_LOAD;
      S_NORM:     cmd.op = OP_NORM_STEP;
      S_LOG_INIT: cmd.op = OP_LOG_INIT;
      S_SQ_MUL:   cmd.op = OP_SQ_MUL;
      S_SQ_UPD:   cmd.op = OP_SQ_UPD;
      S_EXP_E:    cmd.op = OP_EXP_E;
      S_EXP_INIT: cmd.op = OP_EXP_INIT;
      S_EX_MUL:   cmd.op = OP_EXP_MUL;
      S_EX_UPD:   cmd.op = OP_EXP_UPD;
      S_SCALE:    cmd.op = OP_SCALE_MUL;
      S_FINISH:   cmd.op = OP_FINISH;
      default:    cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_DECIDE;
        S_DECIDE: begin
          priority if (stat.op_cal) begin
            state <= (stat.rdy && !stat.adc_zero) ? S_LD_R : S_CAL_SKIP;
          end else if (!stat.rdy) begin
            state <= S_ABORT;
          end else if (stat.adc_zero) begin
            state <= S_ACCUM;
          end else begin
            state <= S_LD_R;
          end
        end
        S_LD_R:     state <= S_DIV_R;
        S_DIV_R:    if (stat.div_last) state <= stat.op_cal ? S_LD_CAL : S_ACCUM;
        S_LD_CAL:   state <= S_DIV_CAL;
        S_DIV_CAL:  if (stat.div_last) state <= S_CAL_SET;
        S_CAL_SET, S_CAL_SKIP, S_ABORT, S_FINISH: state <= S_OUT;
        S_ACCUM:    state <= S_CHECK;
        S_CHECK:    state <= stat.run_full ? S_LD_AVG : S_IDLE;
        S_LD_AVG:   state <= S_DIV_AVG;
        S_DIV_AVG:  if (stat.div_last) state <= S_LD_RAT;
        S_LD_RAT:   state <= S_DIV_RAT;
        S_DIV_RAT:  if (stat.div_last) state <= S_NORM_LD;
        S_NORM_LD:  state <= stat.stop_early ? S_FINISH : S_NORM;
        S_NORM:     if (stat.norm_done) state <= S_LOG_INIT;
        S_LOG_INIT: state <= S_SQ_MUL;
        S_SQ_MUL:   state <= S_SQ_UPD;
        S_SQ_UPD:   state <= stat.it_last ? S_EXP_E : S_SQ_MUL;
        S_EXP_E:    state <= S_EXP_INIT;
        S_EXP_INIT: state <= S_EX_MUL;
        S_EX_MUL:   state <= S_EX_UPD;
        S_EX_UPD:   state <= stat.it_last ? S_SCALE : S_EX_MUL;
        S_SCALE:    state <= S_FINISH;
        S_OUT:      if (load_out) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/gas_sensor_ppm_estimator.sv */
// channel  dir  handshake                  payload
// s        in   s_tvalid / s_tready        s_tdata, s_tuser
// m        out  m_tvalid / m_tready        m_tdata, m_tuser
// cfg      in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one request at a time; a shared 48-step restoring divider sets the pace
// calibration runs two divisions, skip and abort run none, and a mid-run sample with adc 0 skips its division
// run-completing sample adds two divisions, then, unless scale or ratio is zero, a
// leading-one search, 16 squaring and 16 exp2 multiply steps on one 31x31 multiplier
// synchronous reset restores registers and clears the run; cfg always ready
// a pending result sits in the output register while the next request enters
module gas_sensor_ppm_estimator #(
  parameter int unsigned SAMPLES_PER_READING = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // adc_value, zero fill
  input  logic [1:0]                     s_tuser,   // op, conversion_ready
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [47:0]                    m_tdata,   // concentration_ppm, reference_resistance
  output logic [1:0]                     m_tuser,   // status
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gse_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gse_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [15:0] out_ppm;
  logic [31:0] out_ref;

  assign cfg_ready = 1'b1;

  gse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gse_datapath #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_tuser[0]),
    .in_adc     (s_tdata[ADC_W-1:0]),
    .in_rdy     (s_tuser[1]),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_ppm    (out_ppm),
    .out_status (m_tuser),
    .out_ref    (out_ref)
  );

  assign m_tdata = {out_ref, out_ppm};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken twice in a row");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without work");

  a_zero_ppm_unless_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != 2'(ST_DONE)) |-> (m_tdata[15:0] == 16'd0))
    else $error("nonzero ppm on non-measurement result");

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gse_pkg::*;

  localparam int unsigned RUN_LEN     = 10;
  localparam int unsigned SETTLE      = 400;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam longint unsigned LIMIT   = 3000000;

  typedef struct {
    logic [15:0] ppm;
    status_t     status;
    logic [31:0] ref_r;
  } reading_t;

  class ppm_scoreboard;
    logic [15:0]        load_r;
    logic [23:0]        scale;
    logic signed [15:0] expo;
    logic [15:0]        clean_air;
    logic [6:0]         taken;
    logic [39:0]        r_sum;
    logic [31:0]        ref_r;
    logic [63:0]        coef[1:16];
    reading_t           readings_due[$];
    int                 errors;

    function new();
      load_r    = 16'd1000;
      scale     = 24'd19777;
      expo      = -16'sd6709;
      clean_air = 16'd15360;
      taken     = '0;
      r_sum     = '0;
      ref_r     = 32'd256000;
      errors    = 0;
      coef[1]   = root64(64'd1 << 61);
      for (int k = 2; k <= 16; k++) coef[k] = root64(coef[k-1] << 30);
    endfunction

    function logic [63:0] root64(logic [63:0] n);
      logic [63:0] res, b;
      res = '0;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (n >= res + b) begin
          n   = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void set_reg(reg_idx_t idx, logic [23:0] d);
      case (idx)
        REG_LOAD_RES:  load_r    = d[15:0];
        REG_SCALE:     scale     = d;
        REG_EXPONENT:  expo      = d[15:0];
        REG_CLEAN_AIR: clean_air = d[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] sensor_ohms(logic [11:0] adc);
      if (adc == 0) return 0;
      return (64'(load_r) * (64'd4096 - adc) * 64'd256) / adc;
    endfunction

    function logic signed [63:0] log2_q16(logic [63:0] r);
      int p;
      logic [63:0] m;
      logic signed [63:0] frac;
      p    = 63;
      frac = 0;
      while (r[p] == 1'b0) p--;
      m = (p >= 30) ? (r >> (p - 30)) : (r << (30 - p));
      for (int k = 0; k < 16; k++) begin
        m    = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd2 << 30)) begin
          frac = frac | 1;
          m    = m >> 1;
        end
      end
      return 64'(signed'(p - 8)) * 65536 + frac;
    endfunction

    function logic [15:0] curve_ppm(logic [63:0] ratio);
      logic signed [63:0] e, ip, s;
      logic [63:0] f, m, v;
      if (scale == 0) return 0;
      if (ratio == 0) begin
        if (expo < 0) return 16'hFFFF;
        if (expo == 0) return (scale >> 8) > 65535 ? 16'hFFFF : 16'(scale >> 8);
        return 0;
      end
      e  = (log2_q16(ratio) * 64'(expo)) >>> 12;
      ip = e >>> 16;
      f  = e & 64'hFFFF;
      m  = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
        if (f[16-k]) m = (m * coef[k]) >> 30;
      v = 64'(scale) * m;
      s = 38 - ip;
      if (s <= 0) return 16'hFFFF;
      if (s >= 64) return 0;
      v = v >> s;
      return v > 65535 ? 16'hFFFF : 16'(v);
    endfunction

    function void note_request(logic op, logic [11:0] adc, logic rdy);
      reading_t   rd;
      logic [63:0] sum, refv, car, avg;
      rd.ppm = 0;
      if (op) begin
        if (rdy && adc != 0) begin
          car   = clean_air ? 64'(clean_air) : 64'd1;
          refv  = (sensor_ohms(adc) * 256) / car;
          ref_r = refv > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : refv[31:0];
          rd.status = ST_CALIBRATED;
        end else begin
          rd.status = ST_SKIPPED;
        end
      end else if (!rdy) begin
        taken     = 0;
        r_sum     = 0;
        rd.status = ST_ABORTED;
      end else begin
        sum   = 64'(r_sum) + sensor_ohms(adc);
        r_sum = sum > 64'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : sum[39:0];
        taken++;
        if (taken < RUN_LEN) return;
        avg    = r_sum / RUN_LEN;
        refv   = ref_r ? 64'(ref_r) : 64'd1;
        rd.ppm = curve_ppm((avg * 256) / refv);
        taken  = 0;
        r_sum  = 0;
        rd.status = ST_DONE;
      end
      rd.ref_r = ref_r;
      readings_due.push_back(rd);
    endfunction

    function void check_result(logic [15:0] ppm, logic [1:0] st, logic [31:0] refv);
      reading_t rd;
      if (readings_due.size() == 0) begin
        $error("unexpected result ppm=%0d status=%0d ref=%0d", ppm, st, refv);
        errors++;
        return;
      end
      rd = readings_due.pop_front();
      if (ppm !== rd.ppm) begin
        $error("concentration_ppm expected %0d actual %0d", rd.ppm, ppm);
        errors++;
      end
      if (st !== rd.status) begin
        $error("status expected %0d actual %0d", rd.status, st);
        errors++;
      end
      if (refv !== rd.ref_r) begin
        $error("reference_resistance expected %0d actual %0d", rd.ref_r, refv);
        errors++;
      end
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppm_scoreboard   sb;
  bit              no_idle;
  bit              hold_req;
  longint unsigned cycles;

  gas_sensor_ppm_estimator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver side
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[15:0], m_tuser, m_tdata[47:16]);

  task automatic send_sample(logic op, logic [11:0] adc, logic rdy);
    if (!no_idle)
      while ($urandom_range(99) < 26) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, adc};
    s_tuser  <= {rdy, op};
    forever begin
      @(posedge clk);
      if (s_tready) break;
      @(negedge clk);
    end
    sb.note_request(op, adc, rdy);
    @(negedge clk);
  endtask

  task automatic send_run(logic [11:0] adc);
    for (int i = 0; i < RUN_LEN; i++) send_sample(1'b0, adc, 1'b1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [23:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
      @(negedge clk);
    end
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(logic [15:0] ld, logic [23:0] sc, logic [15:0] ex, logic [15:0] ca);
    write_reg(REG_LOAD_RES, 24'(ld));
    write_reg(REG_SCALE, sc);
    write_reg(REG_EXPONENT, 24'(ex));
    write_reg(REG_CLEAN_AIR, 24'(ca));
  endtask

  function automatic logic [23:0] pick(logic [23:0] lo, logic [23:0] hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return 24'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [11:0] rand_adc();
    case ($urandom_range(5))
      0: return 12'($urandom_range(15));
      1: return 12'($urandom_range(4095, 4080));
      2: return $urandom_range(1) ? 12'd0 : 12'd4095;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  task automatic random_items(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) send_sample(1'b1, rand_adc(), $urandom_range(3) != 0);
      else if (r < 14) send_sample(1'b0, rand_adc(), 1'b0);
      else send_sample(1'b0, rand_adc(), 1'b1);
    end
  endtask

  initial begin
    sb        = new();
    cycles    = 0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 0;
    hold_req  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed
    send_sample(1'b0, 12'd0, 1'b1);
    send_sample(1'b0, 12'd4095, 1'b1);
    send_sample(1'b0, 12'd1, 1'b1);
    for (int i = 0; i < 7; i++) send_sample(1'b0, 12'd2048, 1'b1);
    send_sample(1'b0, 12'd300, 1'b1);
    send_sample(1'b0, 12'd123, 1'b0);
    send_sample(1'b1, 12'd2000, 1'b1);
    send_sample(1'b1, 12'd0, 1'b1);
    send_sample(1'b1, 12'd500, 1'b0);
    send_run(12'd4095);
    drain();
    // zero reference
    write_all(16'd1, 24'd19777, 16'hE5CB, 16'hFFFF);
    send_sample(1'b1, 12'd4095, 1'b1);
    send_run(12'd1000);
    drain();
    // zero ratio with negative, zero and positive exponent, the last with zero scale
    write_all(16'hFFFF, 24'hFFFFFF, 16'h8000, 16'd1);
    send_sample(1'b1, 12'd1, 1'b1);
    drain();
    write_reg(REG_LOAD_RES, 24'd1);
    send_run(12'd4095);
    drain();
    write_reg(REG_EXPONENT, 24'd0);
    send_run(12'd4095);
    drain();
    write_reg(REG_EXPONENT, 24'h7FFF);
    write_reg(REG_SCALE, 24'd0);
    send_run(12'd4095);
    drain();

    // random phases
    for (int ph = 0; ph < 7; ph++) begin
      write_all(16'(pick(24'd1, 24'hFFFF)), pick(24'd0, 24'hFFFFFF),
                16'($urandom_range(16'hFFFF)), 16'(pick(24'd1, 24'hFFFF)));
      if (ph == 2) write_reg(REG_EXPONENT, 24'h7FFF);
      no_idle = (ph == 3);
      if (ph == 4) begin
        random_items(20);
        hold_req = 1;
      end
      random_items(190);
      drain();
    end
    write_all(16'd1000, 24'd19777, 16'hE5CB, 16'd15360);
    random_items(60);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
